>>> hw/rtl/dte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_pkg
// Shared constants, types and codes for the digram tree text expander.
// ----------------------------------------------------------------------------
package dte_pkg;

    localparam int CHAR_W          = 8;
    localparam int STACK_DEPTH     = 8;
    localparam int FIRST_PAIR_CODE = 136;
    localparam int MAX_EXPANSION   = 64;
    localparam int PAIR_COUNT      = 256 - FIRST_PAIR_CODE;
    localparam int TABLE_IDX_W     = 7;
    localparam int ENTRY_W         = 2 * CHAR_W;

    localparam int STACK_PTR_W     = $clog2(STACK_DEPTH + 1);
    localparam int STACK_IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int COUNT_W         = $clog2(MAX_EXPANSION + 1);
    localparam int LOOKUP_W        = $clog2(PAIR_COUNT + 1);

    localparam logic [CHAR_W-1:0] TERMINATOR_RESET = CHAR_W'(32);

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_TERMINATOR = 1'b0;

    typedef enum logic {
        KIND_DECODE = 1'b0,
        KIND_WRITE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CHAR_W-1:0]      code;
        logic [TABLE_IDX_W-1:0] index;
        logic [CHAR_W-1:0]      left;
        logic [CHAR_W-1:0]      right;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ
    } state_t;

endpackage

>>> hw/rtl/dte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_front
// Accepts input transactions, classifies them and queues them for the back
// end in a two-entry queue. Out-of-range table writes are dropped here.
// ----------------------------------------------------------------------------
module dte_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [dte_pkg::CHAR_W-1:0]      s_code,
    input  logic [dte_pkg::TABLE_IDX_W-1:0] s_index,
    input  logic [dte_pkg::CHAR_W-1:0]      s_left,
    input  logic [dte_pkg::CHAR_W-1:0]      s_right,
    output logic                          q_valid,
    input  logic                          q_ready,
    output dte_pkg::item_t                q_item
);
    import dte_pkg::*;

    item_t       queue_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        push, pop;
    item_t       in_item;

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        in_item.kind  = s_req_type ? KIND_WRITE : KIND_DECODE;
        in_item.code  = s_code;
        in_item.index = s_index;
        in_item.left  = s_left;
        in_item.right = s_right;
    end

    // drop writes beyond the table
    assign push = s_valid && s_ready &&
                  !(s_req_type && (s_index >= TABLE_IDX_W'(PAIR_COUNT)));
    assign pop  = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hw/rtl/dte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dte_back
// Executes queued transactions: loads the pair table, or expands one code
// byte through the pair table and pending stack into an output register.
// ----------------------------------------------------------------------------
module dte_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [dte_pkg::CHAR_W-1:0] terminator_below,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  dte_pkg::item_t           q_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [dte_pkg::CHAR_W-1:0] m_char,
    output logic                     m_last,
    output logic                     m_eos,
    output logic                     m_ovf
);
    import dte_pkg::*;

    // pair table: left symbol in the upper byte
    logic [ENTRY_W-1:0]     table_mem [PAIR_COUNT];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_en, wr_en;
    logic [TABLE_IDX_W-1:0] rd_addr;

    logic [CHAR_W-1:0]      stack_reg [STACK_DEPTH];
    logic                   push_en;
    logic [STACK_IDX_W-1:0] push_idx, top_idx;

    state_t                 state_reg, state_next;
    logic [CHAR_W-1:0]      ch_reg, ch_next;
    logic [STACK_PTR_W-1:0] depth_reg, depth_next;
    logic [LOOKUP_W-1:0]    lookups_reg, lookups_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_eos_reg, out_eos_next;
    logic                   out_ovf_reg, out_ovf_next;

    logic out_free, is_pair, eos, done, cap, emit;

    assign out_free = !out_valid_reg || m_ready;
    assign is_pair  = (ch_reg >= CHAR_W'(FIRST_PAIR_CODE));
    assign eos      = (ch_reg < terminator_below);
    assign done     = eos || (depth_reg == '0);
    assign cap      = !done && (count_reg >= COUNT_W'(MAX_EXPANSION - 1));
    assign rd_addr  = TABLE_IDX_W'(ch_reg - CHAR_W'(FIRST_PAIR_CODE));
    assign push_idx = STACK_IDX_W'(depth_reg);
    assign top_idx  = STACK_IDX_W'(depth_reg - STACK_PTR_W'(1));
    assign wr_en    = (state_reg == ST_IDLE) && q_valid && (q_item.kind == KIND_WRITE);

    assign m_valid = out_valid_reg;
    assign m_char  = out_char_reg;
    assign m_last  = out_last_reg;
    assign m_eos   = out_eos_reg;
    assign m_ovf   = out_ovf_reg;

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        depth_next    = depth_reg;
        lookups_next  = lookups_reg;
        count_next    = count_reg;
        q_ready       = 1'b0;
        rd_en         = 1'b0;
        push_en       = 1'b0;
        emit          = 1'b0;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_eos_next  = out_eos_reg;
        out_ovf_next  = out_ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid && (q_item.kind == KIND_DECODE)) begin
                    ch_next      = q_item.code;
                    depth_next   = '0;
                    lookups_next = '0;
                    count_next   = '0;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (is_pair) begin
                    if (lookups_reg >= LOOKUP_W'(PAIR_COUNT)) begin
                        // cyclic left chain: give up with a blank result
                        if (out_free) begin
                            emit          = 1'b1;
                            out_char_next = '0;
                            out_last_next = 1'b1;
                            out_eos_next  = 1'b0;
                            out_ovf_next  = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end else begin
                        rd_en        = 1'b1;
                        lookups_next = lookups_reg + LOOKUP_W'(1);
                        state_next   = ST_READ;
                    end
                end else if (out_free) begin
                    emit          = 1'b1;
                    out_char_next = ch_reg;
                    out_last_next = done || cap;
                    out_eos_next  = eos;
                    out_ovf_next  = cap;
                    if (done || cap) begin
                        state_next = ST_IDLE;
                    end else begin
                        ch_next      = stack_reg[top_idx];
                        depth_next   = depth_reg - STACK_PTR_W'(1);
                        lookups_next = '0;
                        count_next   = count_reg + COUNT_W'(1);
                    end
                end
            end
            ST_READ: begin
                // push the right symbol unless full, follow the left one
                if (depth_reg < STACK_PTR_W'(STACK_DEPTH)) begin
                    push_en    = 1'b1;
                    depth_next = depth_reg + STACK_PTR_W'(1);
                end
                ch_next    = rd_data_reg[ENTRY_W-1:CHAR_W];
                state_next = ST_EVAL;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            depth_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg       <= ch_next;
        lookups_reg  <= lookups_next;
        count_reg    <= count_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_eos_reg  <= out_eos_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_reg[push_idx] <= rd_data_reg[CHAR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[q_item.index] <= {q_item.left, q_item.right};
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/digram_tree_text_expander_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digram_tree_text_expander_core
// Expands digram-tree compressed text into plain characters.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per compressed byte (s_tuser = 0) or per
//   pair-table load (s_tuser = 1). Load the table before decoding any pair
//   code that refers to it. Loads past the last pair entry are dropped.
//   m_ channel: one transaction per expanded character; m_tlast marks the
//   final character of one compressed byte, m_tuser flags end of string and
//   a cut-off expansion. Table loads produce no output.
//   Path: a literal byte passes through the queue, the expander registers
//   and the output register on its way to m_. The expander takes each
//   transaction off the queue in its idle state, emits each character from
//   its evaluate state, and runs each pair lookup through the evaluate and
//   read states, as the pair-table read port is registered. A two-entry
//   queue lets the s_ side run ahead while the back end expands.
//   Reset: clears the queue, the expander and the output register, and sets
//   terminator_below to 32; the pair table is not cleared.
//   Stall: with m_tready low the result holds in the output register and
//   the expander waits; once the queue fills, s_tready drops.
//   Config: APB register 0 (address 0) is terminator_below; write it only
//   while the block is idle.
// ----------------------------------------------------------------------------
module digram_tree_text_expander_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] code_byte, [14:8] table_index, [22:15] left_symbol,
    // [30:23] right_symbol, [31] zero
    input  logic [31:0]                    s_tdata,
    // [0] req_type
    input  logic                           s_tuser,
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_char
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast,
    // [0] end_of_string, [1] expansion_overflow
    output logic [1:0]                     m_tuser,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dte_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dte_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dte_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import dte_pkg::*;

    logic [CHAR_W-1:0] terminator_reg, terminator_next;
    logic              cfg_write, reg_sel;
    logic              q_valid, q_ready;
    item_t             q_item;

    // register index lives above the byte offset
    assign reg_sel   = paddr[CFG_ADDR_W-1];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        terminator_next = terminator_reg;
        if (cfg_write && (reg_sel == REG_TERMINATOR)) begin
            terminator_next = pwdata[CHAR_W-1:0];
        end
    end

    always_comb begin
        if (reg_sel == REG_TERMINATOR) begin
            prdata = CFG_DATA_W'(terminator_reg);
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            terminator_reg <= TERMINATOR_RESET;
        end else begin
            terminator_reg <= terminator_next;
        end
    end

    // front end: accept, classify, queue
    dte_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_req_type (s_tuser),
        .s_code     (s_tdata[7:0]),
        .s_index    (s_tdata[14:8]),
        .s_left     (s_tdata[22:15]),
        .s_right    (s_tdata[30:23]),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    // back end: table loads and expansion
    dte_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .terminator_below (terminator_reg),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_char           (m_tdata),
        .m_last           (m_tlast),
        .m_eos            (m_tuser[0]),
        .m_ovf            (m_tuser[1])
    );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the digram tree text expander against a cycle-free predictor.
// A queue of planned transactions feeds a clocked stream driver. A clocked
// monitor compares every expanded character with the oldest expected one.
// The run walks through several terminator settings and idling patterns,
// and holds the result channel off for a long stretch once.
// ----------------------------------------------------------------------------
module testbench;
    import dte_pkg::*;

    // one expanded character as the result channel carries it
    typedef struct {
        logic [7:0] ch;
        bit         last;
        bit         eos;
        bit         ovf;
    } char_result_t;

    localparam logic [CFG_ADDR_W-1:0] TERM_ADDR = CFG_ADDR_W'(4 * REG_TERMINATOR);

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // idling knobs, set by the sequencer between phases
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_off       = 1'b0;

    // planning view of the pair table, updated as transactions are queued
    logic [15:0] plan_mem [PAIR_COUNT];
    bit          plan_written [PAIR_COUNT];

    // predictor state, updated as transactions are accepted
    logic [15:0] pair_mem [PAIR_COUNT];
    logic [7:0]  terminator_reg = TERMINATOR_RESET;

    item_t        pending_items [$];
    char_result_t expected_chars [$];
    item_t        cur_item;
    int           errors = 0;

    digram_tree_text_expander_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one expected character; in planning mode nothing is recorded.
    function automatic void note_char(input logic [7:0] ch, input bit last, input bit eos,
                                      input bit ovf, input bit planning);
        char_result_t r;
        r = '{ch: ch, last: last, eos: eos, ovf: ovf};
        if (!planning)
            expected_chars.push_back(r);
    endfunction

    // Expand one compressed byte. With planning set, walk the planning table
    // instead and return 1 if the walk would touch a pair entry that has not
    // been loaded yet. The planning walk ignores terminators, so it visits
    // every entry that any terminator setting could reach.
    function automatic bit expand_code(input logic [7:0] code, input bit planning);
        logic [7:0]  stack [STACK_DEPTH];
        logic [7:0]  ch;
        logic [7:0]  limit;
        logic [15:0] entry;
        int          depth;
        int          count;
        int          lookups;
        int          idx;
        bit          eos;
        bit          done;
        depth = 0;
        count = 0;
        ch    = code;
        limit = planning ? 8'd0 : terminator_reg;
        while (1'b1) begin
            lookups = 0;
            // follow the left chain, pushing right halves while there is room
            while (ch >= FIRST_PAIR_CODE) begin
                if (lookups >= PAIR_COUNT) begin
                    // the left chain loops back on itself
                    note_char(8'd0, 1'b1, 1'b0, 1'b1, planning);
                    return 1'b0;
                end
                lookups++;
                idx = ch - FIRST_PAIR_CODE;
                if (planning) begin
                    if (!plan_written[idx])
                        return 1'b1;
                    entry = plan_mem[idx];
                end else begin
                    entry = pair_mem[idx];
                end
                if (depth < STACK_DEPTH) begin
                    stack[depth] = entry[7:0];
                    depth++;
                end
                ch = entry[15:8];
            end
            eos  = ch < limit;
            done = eos || depth == 0;
            if (!done && count + 1 >= MAX_EXPANSION) begin
                // result cap reached with work still pending
                note_char(ch, 1'b1, 1'b0, 1'b1, planning);
                return 1'b0;
            end
            note_char(ch, done, eos, 1'b0, planning);
            count++;
            if (done)
                return 1'b0;
            depth--;
            ch = stack[depth];
        end
        return 1'b0;
    endfunction

    // Advance the predictor by one accepted transaction.
    function automatic void record_transaction(input item_t it);
        if (it.kind == KIND_WRITE) begin
            if (it.index < PAIR_COUNT)
                pair_mem[it.index] = {it.left, it.right};
        end else begin
            void'(expand_code(it.code, 1'b0));
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------

    task automatic queue_write(input logic [6:0] idx, input logic [7:0] l,
                               input logic [7:0] r);
        item_t it;
        it = '{kind: KIND_WRITE, code: 8'($urandom), index: idx, left: l, right: r};
        if (idx < PAIR_COUNT) begin
            plan_mem[idx]     = {l, r};
            plan_written[idx] = 1'b1;
        end
        pending_items.push_back(it);
    endtask

    task automatic queue_decode(input logic [7:0] c);
        item_t it;
        it = '{kind: KIND_DECODE, code: c, index: 7'($urandom),
               left: 8'($urandom), right: 8'($urandom)};
        pending_items.push_back(it);
    endtask

    // Prefer codes of entries already loaded; fall back to any pair code.
    function automatic logic [7:0] pick_pair_code();
        int idx;
        for (int t = 0; t < 16; t++) begin
            idx = $urandom_range(PAIR_COUNT - 1);
            if (plan_written[idx])
                return 8'(FIRST_PAIR_CODE + idx);
        end
        return 8'($urandom_range(255, FIRST_PAIR_CODE));
    endfunction

    function automatic logic [7:0] pick_symbol();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'($urandom_range(31));
        if (r < 50)
            return 8'($urandom_range(126, 32));
        if (r < 60)
            return 8'($urandom_range(FIRST_PAIR_CODE - 1, 127));
        return pick_pair_code();
    endfunction

    // Mostly decodes of loaded pair codes, interleaved with table loads,
    // plain literals and the occasional out-of-range load.
    task automatic queue_random(input int n);
        int unsigned r;
        logic [7:0]  code;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 2) begin
                queue_write(7'($urandom_range(127, PAIR_COUNT)), 8'($urandom), 8'($urandom));
            end else if (r < 25) begin
                queue_write(7'($urandom_range(PAIR_COUNT - 1)), pick_symbol(), pick_symbol());
            end else if (r < 45) begin
                queue_decode(8'($urandom_range(FIRST_PAIR_CODE - 1)));
            end else begin
                code = pick_pair_code();
                // never decode into an entry that has not been loaded
                if (expand_code(code, 1'b1))
                    code = 8'($urandom_range(FIRST_PAIR_CODE - 1));
                queue_decode(code);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input stream driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // a transaction completes at this edge: predict its results
            if (s_tvalid && s_tready)
                record_transaction(cur_item);
            // offer the next item once the current one is gone
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_tdata  <= {1'b0, cur_item.right, cur_item.left,
                                 cur_item.index, cur_item.code};
                    s_tuser  <= cur_item.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stream monitor
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input int exp_v,
                                          input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        char_result_t exp_c;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character, expected none, got %0d",
                             $time, m_tdata);
                    errors++;
                end else begin
                    exp_c = expected_chars.pop_front();
                    compare_field("out_char", exp_c.ch, m_tdata);
                    compare_field("last", exp_c.last, m_tlast);
                    compare_field("end_of_string", exp_c.eos, m_tuser[0]);
                    compare_field("expansion_overflow", exp_c.ovf, m_tuser[1]);
                end
            end
            m_tready <= !hold_off && $urandom_range(99) >= recv_stall_pct;
        end
    end

    // ------------------------------------------------------------------
    // Configuration access
    // ------------------------------------------------------------------
    task automatic read_terminator(input logic [7:0] exp_v);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= TERM_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // access phase ends at this edge; sample the value it presented
        if (prdata[7:0] !== exp_v) begin
            $display("%0t: terminator_below readback mismatch, expected %0d, got %0d",
                     $time, exp_v, prdata[7:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_terminator(input logic [7:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TERM_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register loads at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        terminator_reg = value;
        read_terminator(value);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        @(posedge aclk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Hold until every queued transaction is taken and every expected
    // character has arrived, then let a trailing load settle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset value, then an explicit write of the default
        read_terminator(TERMINATOR_RESET);
        write_terminator(8'd32);

        // directed: literal extremes, terminators below the threshold
        queue_decode(8'd0);
        queue_decode(8'd31);
        queue_decode(8'd32);
        queue_decode(8'(FIRST_PAIR_CODE - 1));
        queue_decode(8'd65);
        // table loads: plain pair, nested pair at the last index, a pair
        // whose right half names itself (runs into the result cap), a pair
        // whose left half names itself (cyclic chain, fills the stack and
        // drops the rest), symbol extremes, terminator popped from the stack
        queue_write(7'd0, 8'h48, 8'h69);
        queue_write(7'(PAIR_COUNT - 1), 8'(FIRST_PAIR_CODE), 8'h7A);
        queue_write(7'd1, 8'h61, 8'(FIRST_PAIR_CODE + 1));
        queue_write(7'd2, 8'(FIRST_PAIR_CODE + 2), 8'h71);
        queue_write(7'd5, 8'h00, 8'hFF);
        queue_write(7'd6, 8'h7E, 8'h00);
        // loads past the last entry are dropped
        queue_write(7'd127, 8'h01, 8'h02);
        queue_write(7'(PAIR_COUNT), 8'h03, 8'h04);
        queue_decode(8'(FIRST_PAIR_CODE));
        queue_decode(8'd255);
        queue_decode(8'(FIRST_PAIR_CODE + 1));
        queue_decode(8'(FIRST_PAIR_CODE + 2));
        queue_decode(8'(FIRST_PAIR_CODE + 5));
        queue_decode(8'(FIRST_PAIR_CODE + 6));
        wait_drained();

        // threshold above the first pair code: pair bytes still expand
        write_terminator(8'd200);
        queue_decode(8'(FIRST_PAIR_CODE));
        queue_decode(8'(FIRST_PAIR_CODE + 6));
        queue_decode(8'(FIRST_PAIR_CODE - 1));
        queue_random(20);
        wait_drained();

        // no terminators at all, sender mostly idle; reload the entry first,
        // the random loads may have pointed it at unloaded entries
        write_terminator(8'd0);
        set_idling(83, 0);
        queue_write(7'd5, 8'h00, 8'hFF);
        queue_decode(8'(FIRST_PAIR_CODE + 5));
        queue_random(20);
        wait_drained();

        // every literal terminates, receiver mostly stalled
        write_terminator(8'd255);
        set_idling(0, 83);
        queue_random(20);
        wait_drained();

        // random threshold, both sides idling
        write_terminator(8'($urandom_range(254, 1)));
        set_idling(30, 30);
        queue_random(20);
        wait_drained();

        // long receiver hold-off while the sender keeps offering, so the
        // input queue fills and s_tready drops
        write_terminator(8'd32);
        set_idling(0, 0);
        hold_off <= 1'b1;
        queue_random(20);
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
        wait_drained();

        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
